// File: rtl/core/evu_pkg.sv
package evu_pkg;

    localparam int XW = 63;                          // Q1.62 mantissa
    localparam int LW = 56;                          // log2 fraction bits
    localparam int PW = 6;                           // exponent index
    localparam int QW = 62;                          // dividend / quotient width
    localparam int RMW = 32;                         // divider remainder
    localparam int SW = 48;                          // sample width
    localparam int NSQ = 56;                         // squaring cells
    localparam logic [63:0] LN2_Q64 = 64'hB17217F7D1CF79AB;

    localparam logic [2:0] ADDR_RATE = 3'd0;

    typedef struct packed {
        logic          valid;
        logic          last;
        logic [PW-1:0] p;
        logic [XW-1:0] x;
        logic [LW-1:0] l;
    } t_lg;

    typedef struct packed {
        logic           valid;
        logic           last;
        logic [QW-1:0]  w;
        logic [RMW-1:0] rem;
    } t_dv;

endpackage

// File: rtl/core/evu_sq_cell.sv
// One log2 bit: square the mantissa over two stages, renormalise, shift in the bit.
module evu_sq_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  evu_pkg::t_lg  i_d,
    output evu_pkg::t_lg  o_d
);

    logic                        r_va;
    logic                        r_last_a;
    logic [evu_pkg::PW-1:0]      r_p_a;
    logic [evu_pkg::LW-1:0]      r_l_a;
    logic [61:0]                 r_p11;
    logic [62:0]                 r_p10;
    logic [63:0]                 r_p00;
    evu_pkg::t_lg                r_out;
    evu_pkg::t_lg                n_out;
    logic [125:0]                sq;
    logic [63:0]                 top;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
        end else if (i_en) begin
            r_va <= i_d.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_last_a <= i_d.last;
            r_p_a    <= i_d.p;
            r_l_a    <= i_d.l;
            r_p11    <= i_d.x[62:32] * i_d.x[62:32];
            r_p10    <= i_d.x[62:32] * i_d.x[31:0];
            r_p00    <= i_d.x[31:0] * i_d.x[31:0];
        end
    end

    always_comb begin
        sq  = {r_p11, 64'd0} + {30'd0, r_p10, 33'd0} + {62'd0, r_p00};
        top = sq[125:62];
        n_out.valid = r_va;
        n_out.last  = r_last_a;
        n_out.p     = r_p_a;
        if (top[63]) begin
            n_out.x = top[63:1];
            n_out.l = {r_l_a[evu_pkg::LW-2:0], 1'b1};
        end else begin
            n_out.x = top[62:0];
            n_out.l = {r_l_a[evu_pkg::LW-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out.valid <= 1'b0;
        end else if (i_en) begin
            r_out.valid <= n_out.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out.last <= n_out.last;
            r_out.p    <= n_out.p;
            r_out.x    <= n_out.x;
            r_out.l    <= n_out.l;
        end
    end

    assign o_d = r_out;

endmodule

// File: rtl/core/evu_div_cell.sv
// One restoring division step: shift in a dividend bit, subtract if it fits.
module evu_div_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic [31:0]   i_rate,
    input  evu_pkg::t_dv  i_d,
    output evu_pkg::t_dv  o_d
);

    evu_pkg::t_dv r_out;
    logic [32:0]  trial;
    logic [33:0]  diff;
    logic         ge;

    always_comb begin
        trial = {i_d.rem, i_d.w[evu_pkg::QW-1]};
        diff  = {1'b0, trial} - {2'b00, i_rate};
        ge    = ~diff[33];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out.valid <= 1'b0;
        end else if (i_en) begin
            r_out.valid <= i_d.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out.last <= i_d.last;
            r_out.w    <= {i_d.w[evu_pkg::QW-2:0], ge};
            r_out.rem  <= ge ? diff[31:0] : trial[31:0];
        end
    end

    assign o_d = r_out;

endmodule

// File: rtl/core/exponential_variate_from_uniform_unit.sv
// Exponential variate from two uniform random words, by inverse transform:
// sample = -ln(1 - u) / rate, u being the low FRACTION_BITS bits of the joined
// words, returned with OUT_FRACTION_BITS fraction bits and saturated at 2^48-1
// (o_saturated flags it; a zero rate saturates every sample). One transfer is
// taken per cycle while o_ready is high; results come out in order through an
// input register, the chain of 56 squaring cells (two stages each) that form
// log2, the ln 2 scaling (three stages), the chain of 62 restoring divider
// cells and the output register. The whole pipeline advances together and
// holds while a result waits unaccepted. rate is the only register, Q16.16 at
// byte address 0, reset to 1.0; write it only while the pipeline is empty.
module exponential_variate_from_uniform_unit #(
    parameter int FRACTION_BITS     = 24,
    parameter int OUT_FRACTION_BITS = 24
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_word_high,
    input  logic [31:0] i_word_low,
    input  logic        i_last_in,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [47:0] o_sample,
    output logic        o_saturated,
    output logic        o_last_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int SHR = 40 - OUT_FRACTION_BITS;

    logic [31:0]         r_rate;
    logic                en;
    logic                r_ovalid;
    logic [47:0]         r_sample;
    logic                r_sat;
    logic                r_olast;

    evu_pkg::t_lg        lg [0:evu_pkg::NSQ];
    evu_pkg::t_lg        r_lg0;
    evu_pkg::t_lg        n_lg0;
    evu_pkg::t_dv        dv [0:evu_pkg::QW];
    evu_pkg::t_dv        r_dv0;

    logic [63:0]         k;
    logic [63:0]         m;
    logic [62:0]         v;
    logic [5:0]          cnt;

    logic                r_yv, r_ylast;
    logic [63:0]         r_y;
    logic [5:0]          fp;
    logic                r_mv, r_mlast;
    logic [63:0]         r_m11, r_m10, r_m01, r_m00;
    logic [127:0]        prod;
    logic [63:0]         z;
    logic [63:0]         num;
    logic [evu_pkg::QW-1:0] q;
    logic                sat;

    // ---------------- configuration ----------------
    assign pready = 1'b1;
    assign prdata = (paddr == evu_pkg::ADDR_RATE) ? r_rate : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate <= 32'd65536;
        end else if (psel && penable && pwrite && (paddr == evu_pkg::ADDR_RATE)) begin
            r_rate <= pwdata;
        end
    end

    // Advance everything unless the output register holds an untaken result.
    assign en      = ~r_ovalid | i_ready;
    assign o_ready = en;

    // ---------------- normalise 1 - u into [1,2) ----------------
    always_comb begin
        k   = {i_word_high, i_word_low} & ((64'd1 << FRACTION_BITS) - 64'd1);
        m   = (64'd1 << FRACTION_BITS) - k;
        v   = m[62:0];
        cnt = 6'd0;
        if (v[62:31] == 32'd0) begin v = v << 32; cnt = cnt + 6'd32; end
        if (v[62:47] == 16'd0) begin v = v << 16; cnt = cnt + 6'd16; end
        if (v[62:55] == 8'd0)  begin v = v << 8;  cnt = cnt + 6'd8;  end
        if (v[62:59] == 4'd0)  begin v = v << 4;  cnt = cnt + 6'd4;  end
        if (v[62:61] == 2'd0)  begin v = v << 2;  cnt = cnt + 6'd2;  end
        if (!v[62])            begin v = v << 1;  cnt = cnt + 6'd1;  end
        n_lg0.valid = i_valid;
        n_lg0.last  = i_last_in;
        n_lg0.p     = 6'd62 - cnt;
        n_lg0.x     = v;
        n_lg0.l     = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lg0.valid <= 1'b0;
        end else if (en) begin
            r_lg0.valid <= n_lg0.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_lg0.last <= n_lg0.last;
            r_lg0.p    <= n_lg0.p;
            r_lg0.x    <= n_lg0.x;
            r_lg0.l    <= n_lg0.l;
        end
    end

    assign lg[0] = r_lg0;

    // ---------------- log2 by repeated squaring ----------------
    genvar gi;
    generate
        for (gi = 0; gi < evu_pkg::NSQ; gi++) begin : g_sq
            evu_sq_cell u_sq (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_en    (en),
                .i_d     (lg[gi]),
                .o_d     (lg[gi+1])
            );
        end
    endgenerate

    // ---------------- -log2(1-u), then scale by ln 2 ----------------
    assign fp = 6'(FRACTION_BITS) - lg[evu_pkg::NSQ].p;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_yv <= 1'b0;
            r_mv <= 1'b0;
        end else if (en) begin
            r_yv <= lg[evu_pkg::NSQ].valid;
            r_mv <= r_yv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ylast <= lg[evu_pkg::NSQ].last;
            r_y     <= {2'b00, fp, 56'd0} - {8'd0, lg[evu_pkg::NSQ].l};
            r_mlast <= r_ylast;
            r_m11   <= r_y[63:32] * evu_pkg::LN2_Q64[63:32];
            r_m10   <= r_y[63:32] * evu_pkg::LN2_Q64[31:0];
            r_m01   <= r_y[31:0]  * evu_pkg::LN2_Q64[63:32];
            r_m00   <= r_y[31:0]  * evu_pkg::LN2_Q64[31:0];
        end
    end

    // Keep the high half of the product, then fold the output scaling into the dividend.
    always_comb begin
        prod = {r_m11, 64'd0} + {32'd0, r_m10, 32'd0} + {32'd0, r_m01, 32'd0}
             + {64'd0, r_m00};
        z    = prod[127:64];
        num  = z >> SHR;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv0.valid <= 1'b0;
        end else if (en) begin
            r_dv0.valid <= r_mv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dv0.last <= r_mlast;
            r_dv0.w    <= num[evu_pkg::QW-1:0];
            r_dv0.rem  <= '0;
        end
    end

    assign dv[0] = r_dv0;

    // ---------------- divide by rate, one quotient bit per cell ----------------
    generate
        for (gi = 0; gi < evu_pkg::QW; gi++) begin : g_div
            evu_div_cell u_div (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_en    (en),
                .i_rate  (r_rate),
                .i_d     (dv[gi]),
                .o_d     (dv[gi+1])
            );
        end
    endgenerate

    // ---------------- saturate and hold for transfer ----------------
    assign q   = dv[evu_pkg::QW].w;
    assign sat = |q[evu_pkg::QW-1:evu_pkg::SW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (en) begin
            r_ovalid <= dv[evu_pkg::QW].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sample <= sat ? {evu_pkg::SW{1'b1}} : q[evu_pkg::SW-1:0];
            r_sat    <= sat;
            r_olast  <= dv[evu_pkg::QW].last;
        end
    end

    assign o_valid     = r_ovalid;
    assign o_sample    = r_sample;
    assign o_saturated = r_sat;
    assign o_last_out  = r_olast;

endmodule
